/* hdl/fdmd_pkg.sv */
// Shared types and constants for the frame-difference motion detector.
// Used by fdmd_alu and frame_difference_motion_detector_unit; no dependencies.
package fdmd_pkg;

  localparam int PIX_W      = 8;
  localparam int CNT_W      = 18;
  localparam int FRAC_W     = 17;
  localparam int FRAC_BITS  = 16;
  localparam int ALU_W      = CNT_W + 1;
  localparam int WARMUP_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam int DEF_MAX_PIXELS  = 131072;
  localparam int DEF_WARMUP_SKIP = 6;

  localparam logic [PIX_W-1:0]  RST_DIFF_THRESHOLD   = PIX_W'(100);
  localparam logic [CNT_W-1:0]  RST_NOISE_MIN_PIXELS = CNT_W'(10);
  localparam logic [CNT_W-1:0]  RST_FRAME_PIXELS     = CNT_W'(76800);
  localparam logic [CNT_W-1:0]  COUNT_MAX            = {CNT_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_ONE             = FRAC_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_THRESHOLD   = 2'd0,
    CFG_NOISE_MIN_PIXELS = 2'd1,
    CFG_FRAME_PIXELS     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ALU_SUB,
    ALU_ABSDIFF
  } alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] result;
    logic             borrow;
  } alu_res_t;

endpackage

/* hdl/fdmd_alu.sv */
// Shared subtract unit: a minus b with borrow, or the absolute difference.
// Depends on fdmd_pkg.
module fdmd_alu (
  input  fdmd_pkg::alu_op_t           op,
  input  logic [fdmd_pkg::ALU_W-1:0]  a,
  input  logic [fdmd_pkg::ALU_W-1:0]  b,
  output fdmd_pkg::alu_res_t          res
);
  import fdmd_pkg::*;

  logic [ALU_W:0] a_minus_b;
  logic [ALU_W:0] b_minus_a;

  assign a_minus_b = {1'b0, a} - {1'b0, b};
  assign b_minus_a = {1'b0, b} - {1'b0, a};

  always_comb begin
    res.borrow = a_minus_b[ALU_W];
    unique case (op)
      ALU_SUB:     res.result = a_minus_b[ALU_W-1:0];
      ALU_ABSDIFF: res.result = a_minus_b[ALU_W] ? b_minus_a[ALU_W-1:0]
                                                 : a_minus_b[ALU_W-1:0];
      default:     res.result = a_minus_b[ALU_W-1:0];
    endcase
  end

endmodule

/* hdl/frame_difference_motion_detector_unit.sv */
// Frame-difference motion detector: top level with sequencer and frame store.
// Depends on fdmd_pkg and fdmd_alu.
// A pixel word: idle, diff, threshold (idle only in warm-up). A frame end adds
// noise and divide checks, the divider and output, held while a report waits.
// After reset both frame buffers are cleared, and no pixel word is taken until
// that is done; configuration writes are taken at all times.
module frame_difference_motion_detector_unit #(
  parameter int MAX_PIXELS  = fdmd_pkg::DEF_MAX_PIXELS,
  parameter int WARMUP_SKIP = fdmd_pkg::DEF_WARMUP_SKIP
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fdmd_pkg::PIX_W-1:0]         pixel,
  input  logic                               last_in_frame,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fdmd_pkg::CNT_W-1:0]         changed_count,
  output logic [fdmd_pkg::FRAC_W-1:0]        motion_fraction,
  output logic                               reference_updated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fdmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fdmd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fdmd_pkg::*;

  localparam int AW     = $clog2(MAX_PIXELS);
  localparam int DEPTH  = 2 * MAX_PIXELS;
  localparam int MW     = $clog2(DEPTH);
  localparam int ITER_W = $clog2(FRAC_BITS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIFF,
    S_THRESH,
    S_NOISE,
    S_DIVCHK,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  logic [PIX_W-1:0]     diff_threshold;
  logic [CNT_W-1:0]     noise_min_pixels;
  logic [CNT_W-1:0]     frame_pixels;

  logic                 reference_select;
  logic [AW-1:0]        pixel_address;
  logic [CNT_W-1:0]     changed_counter;
  logic [WARMUP_W-1:0]  warmup_frames;
  logic [MW-1:0]        clear_address;

  logic [PIX_W-1:0]     pixel_q;
  logic                 last_q;
  logic [PIX_W-1:0]     abs_diff;
  logic                 update_q;
  logic [CNT_W-1:0]     remainder;
  logic [FRAC_BITS-1:0] quotient;
  logic [ITER_W-1:0]    iteration;
  logic [FRAC_W-1:0]    fraction_q;

  logic [PIX_W-1:0]     mem [DEPTH];
  logic [PIX_W-1:0]     ref_data;
  logic                 mem_we;
  logic                 mem_re;
  logic [MW-1:0]        mem_waddr;
  logic [MW-1:0]        mem_raddr;
  logic [PIX_W-1:0]     mem_wdata;

  alu_op_t              alu_op;
  logic [ALU_W-1:0]     alu_a;
  logic [ALU_W-1:0]     alu_b;
  alu_res_t             alu_res;

  logic [AW-1:0]        address_next;
  logic                 in_accept;
  logic                 in_warmup;
  logic                 out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign in_warmup = (warmup_frames < WARMUP_W'(WARMUP_SKIP));
  assign out_free  = !out_valid || out_ready;

  assign address_next = (pixel_address == AW'(MAX_PIXELS - 1)) ? '0 : pixel_address + 1'b1;

  assign mem_re    = in_accept && !in_warmup;
  assign mem_raddr = MW'(pixel_address) + (reference_select ? MW'(MAX_PIXELS) : '0);
  assign mem_we    = (state == S_CLEAR) || (state == S_THRESH);
  assign mem_waddr = (state == S_CLEAR) ? clear_address
                   : MW'(pixel_address) + (reference_select ? '0 : MW'(MAX_PIXELS));
  assign mem_wdata = (state == S_CLEAR) ? '0 : pixel_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      ref_data <= mem[mem_raddr];
    end
  end

  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_DIFF: begin
        alu_op = ALU_ABSDIFF;
        alu_a  = ALU_W'(pixel_q);
        alu_b  = ALU_W'(ref_data);
      end
      S_THRESH: begin
        alu_a = ALU_W'(diff_threshold);
        alu_b = ALU_W'(abs_diff);
      end
      S_NOISE: begin
        alu_a = ALU_W'(changed_counter);
        alu_b = ALU_W'(noise_min_pixels);
      end
      S_DIVCHK: begin
        alu_a = ALU_W'(changed_counter);
        alu_b = ALU_W'(frame_pixels);
      end
      S_DIV: begin
        alu_a = {remainder, 1'b0};
        alu_b = ALU_W'(frame_pixels);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  fdmd_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      diff_threshold   <= RST_DIFF_THRESHOLD;
      noise_min_pixels <= RST_NOISE_MIN_PIXELS;
      frame_pixels     <= RST_FRAME_PIXELS;
      reference_select <= 1'b0;
      pixel_address    <= '0;
      changed_counter  <= '0;
      warmup_frames    <= '0;
      clear_address    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DIFF_THRESHOLD:   diff_threshold   <= cfg_data[PIX_W-1:0];
          CFG_NOISE_MIN_PIXELS: noise_min_pixels <= cfg_data[CNT_W-1:0];
          CFG_FRAME_PIXELS:     frame_pixels     <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clear_address <= clear_address + 1'b1;
          if (clear_address == MW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            pixel_q <= pixel;
            last_q  <= last_in_frame;
            if (in_warmup) begin
              if (last_in_frame) begin
                warmup_frames <= warmup_frames + 1'b1;
                pixel_address <= '0;
              end else begin
                pixel_address <= address_next;
              end
            end else begin
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          abs_diff <= alu_res.result[PIX_W-1:0];
          state    <= S_THRESH;
        end
        S_THRESH: begin
          if (alu_res.borrow && (changed_counter != COUNT_MAX)) begin
            changed_counter <= changed_counter + 1'b1;
          end
          if (last_q) begin
            pixel_address <= '0;
            state         <= S_NOISE;
          end else begin
            pixel_address <= address_next;
            state         <= S_IDLE;
          end
        end
        S_NOISE: begin
          update_q <= !alu_res.borrow;
          state    <= S_DIVCHK;
        end
        S_DIVCHK: begin
          if (changed_counter == '0) begin
            fraction_q <= '0;
            state      <= S_OUT;
          end else if (!alu_res.borrow) begin
            fraction_q <= FRAC_ONE;
            state      <= S_OUT;
          end else begin
            remainder <= changed_counter;
            quotient  <= '0;
            iteration <= '0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (alu_res.borrow) begin
            remainder <= alu_a[CNT_W-1:0];
          end else begin
            remainder <= alu_res.result[CNT_W-1:0];
          end
          quotient  <= {quotient[FRAC_BITS-2:0], !alu_res.borrow};
          iteration <= iteration + 1'b1;
          if (iteration == ITER_W'(FRAC_BITS - 1)) begin
            fraction_q <= FRAC_W'({quotient[FRAC_BITS-2:0], !alu_res.borrow});
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            changed_count     <= changed_counter;
            motion_fraction   <= fraction_q;
            reference_updated <= update_q;
            if (update_q) begin
              reference_select <= !reference_select;
            end
            changed_counter <= '0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
